// ----- sv/dif_pkg.sv -----
package dif_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam int         MAX_DIGITS = 20;

   // Number of decimal digits in the largest magnitude, 2**(bits-1).
   function automatic int digits_for(input int bits);
      longint unsigned v;
      int              n;
      v = 64'd1 << (bits - 1);
      n = 1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (v >= 64'd10) begin
            v = v / 64'd10;
            n = n + 1;
         end
      end
      return n;
   endfunction

   typedef struct packed {
      logic load;
      logic step;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic conv_last;
      logic neg;
      logic idx_zero;
      logic out_free;
   } status_type;

endpackage

// ----- sv/dif_if.sv -----
interface dif_req_if #(parameter int VALUE_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface dif_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- sv/dif_ctrl.sv -----
module dif_ctrl
   import dif_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CONV  = 2'd1;
   localparam logic [1:0] ST_SIGN  = 2'd2;
   localparam logic [1:0] ST_DIGIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            if (status.conv_last) begin
               state_in = status.neg ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.idx_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/dif_datapath.sv -----
module dif_datapath
   import dif_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [VALUE_BITS-1:0] value,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_char_code,
   output logic                  rsp_last
);

   localparam int NUM_DIGITS = digits_for(VALUE_BITS);
   localparam int IDX_W      = $clog2(NUM_DIGITS);
   localparam int CNT_W      = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] mag_ff;
   logic [VALUE_BITS-1:0] mag_in;
   logic                  neg_ff;
   logic                  neg_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      idx_in;
   logic [3:0]            digit_ff [NUM_DIGITS];
   logic [3:0]            digit_in [NUM_DIGITS];
   logic [3:0]            adj      [NUM_DIGITS];
   logic [3:0]            shifted  [NUM_DIGITS];
   logic                  valid_ff;
   logic                  valid_in;
   logic [7:0]            char_ff;
   logic [7:0]            char_in;
   logic                  last_ff;
   logic                  last_in;
   logic [IDX_W-1:0]      idx_up;
   logic                  grow;

   assign status.conv_last = (cnt_ff == '0);
   assign status.neg       = neg_ff;
   assign status.idx_zero  = (idx_ff == '0);
   assign status.out_free  = !valid_ff || rsp_ready;

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

   // One shift-and-add-three step of the binary to BCD conversion.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (digit_ff[i] >= 4'd5) ? (digit_ff[i] + 4'd3) : digit_ff[i];
      end
      shifted[0] = {adj[0][2:0], mag_ff[VALUE_BITS-1]};
      for (int i = 1; i < NUM_DIGITS; i++) begin
         shifted[i] = {adj[i][2:0], adj[i-1][3]};
      end
   end

   // The value at most doubles per step, so the text grows by one digit at most.
   assign idx_up = idx_ff + 1'b1;
   assign grow   = (idx_ff != IDX_W'(NUM_DIGITS - 1)) && (shifted[idx_up] != 4'd0);

   always_comb begin
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      digit_in = digit_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_ready;
      if (cmd.load) begin
         neg_in = value[VALUE_BITS-1];
         mag_in = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
         cnt_in = CNT_W'(VALUE_BITS - 1);
         idx_in = '0;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_in[i] = 4'd0;
         end
      end
      if (cmd.step) begin
         mag_in   = mag_ff << 1;
         cnt_in   = cnt_ff - 1'b1;
         digit_in = shifted;
         if (grow) begin
            idx_in = idx_up;
         end
      end
      if (cmd.emit_sign) begin
         valid_in = 1'b1;
         char_in  = CHAR_MINUS;
         last_in  = 1'b0;
      end
      if (cmd.emit_digit) begin
         valid_in = 1'b1;
         char_in  = CHAR_ZERO + {4'd0, digit_ff[idx_ff]};
         last_in  = (idx_ff == '0);
         idx_in   = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      digit_ff <= digit_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

endmodule

// ----- sv/decimal_integer_formatter.sv -----
// Signed binary to decimal ASCII formatter.
//
// The request channel carries one signed two's-complement value per
// transaction. The response channel returns its decimal text, one character
// per transaction, most significant digit first, with a leading '-' for a
// negative value and a single '0' for zero. The final character of a number
// has last set. The most negative value is formatted in full.
//
// The request is accepted only when the block is idle. The value is then
// converted by a shift-and-add-three loop that takes one bit per cycle, and
// the first character is offered once every bit is converted. Characters
// then leave at one per cycle while the receiver is ready. The next request
// is taken in the cycle after the last character is registered, while that
// character may still be waiting.
//
// A stalled receiver holds the current character steady and holds back the
// next one; the conversion itself does not wait for it. Synchronous reset
// returns the block to idle and drops any pending character.
module decimal_integer_formatter
   import dif_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input logic                 clock,
   input logic                 reset,
   dif_req_if.sink             req_ch,
   dif_rsp_if.source           rsp_ch
);

   cmd_type    cmd;
   status_type status;

   dif_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dif_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .value         (req_ch.value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_char_code (rsp_ch.char_code),
      .rsp_last      (rsp_ch.last)
   );

endmodule

// ----- dv/tb_decimal_integer_formatter.sv -----
module tb_decimal_integer_formatter;
   timeunit 1ns;
   timeprecision 1ps;
   import dif_pkg::*;

   localparam int VALUE_BITS     = 32;
   localparam int DIRECTED_COUNT = 22;
   localparam int RANDOM_COUNT   = 250;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } text_char_type;

   logic clock;
   logic reset;

   dif_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   dif_rsp_if                            rsp_ch ();

   decimal_integer_formatter #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   text_char_type expected_text[$];
   int unsigned   error_count      = 0;
   int unsigned   req_idle_pct     = 0;
   int unsigned   rsp_idle_pct     = 0;
   bit            hold_off_request = 1'b0;

   // An empty string means that the characters are predicted.
   logic signed [VALUE_BITS-1:0] directed_value [DIRECTED_COUNT] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd7, 32'sd9, 32'sd10, -32'sd9, -32'sd10,
      32'sd99, 32'sd100, 32'sd12345, -32'sd987654321, 32'sd999999999,
      32'sd1000000000, -32'sd1000000000, 32'sh5555_5555, 32'shAAAA_AAAA,
      32'sh7FFF_FFFF, 32'sh8000_0001, 32'sh8000_0000, 32'sh7FFF_FFFE, 32'sd0
   };
   string directed_text [DIRECTED_COUNT] = '{
      "0", "1", "-1", "", "", "", "", "",
      "", "", "", "", "",
      "", "", "", "",
      "2147483647", "-2147483647", "-2147483648", "", "0"
   };

   function automatic void format_decimal(input logic [VALUE_BITS-1:0] raw);
      logic [VALUE_BITS-1:0] magnitude;
      logic [3:0]            digit_buf [24];
      int                    count;
      magnitude = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
      count = 0;
      do begin
         digit_buf[count] = 4'(magnitude % 10);
         count++;
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (raw[VALUE_BITS-1]) begin
         expected_text.push_back('{char_code: CHAR_MINUS, last: 1'b0});
      end
      for (int i = count - 1; i >= 0; i--) begin
         expected_text.push_back('{char_code: CHAR_ZERO + 8'(digit_buf[i]),
                                   last: (i == 0)});
      end
   endfunction

   function automatic void expect_typed(input string text);
      for (int i = 0; i < text.len(); i++) begin
         expected_text.push_back('{char_code: text[i], last: (i == text.len() - 1)});
      end
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] v;
      logic [VALUE_BITS-1:0] decade;
      decade = 1;
      case ($urandom_range(3))
         0: begin
            v = $urandom;
         end
         1: begin
            v = $urandom_range(999);
            if ($urandom_range(1)) v = -v;
         end
         2: begin
            repeat ($urandom_range(9)) decade = decade * 10;
            v = decade + $urandom_range(2) - 1;
            if ($urandom_range(1)) v = -v;
         end
         default: begin
            case ($urandom_range(4))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = 32'h8000_0001;
               3:       v = '0;
               default: v = '1;
            endcase
         end
      endcase
      return v;
   endfunction

   // Called and returning at a falling edge; valid stays high on return.
   task automatic send_value(input logic [VALUE_BITS-1:0] v, input string text);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         req_ch.value <= $urandom;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      if (text.len() == 0) format_decimal(v);
      else expect_typed(text);
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : drive_ready
      int unsigned hold_cycles;
      bit          hold_seen;
      hold_cycles = 0;
      hold_seen = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_seen) begin
            hold_cycles = HOLD_OFF_CYCLES;
            hold_seen = 1'b1;
         end
         if (hold_cycles != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_text
      text_char_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_text.size() == 0) begin
            $error("char_code: expected none, actual %0d", rsp_ch.char_code);
            error_count++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_ch.char_code !== want.char_code) begin
               $error("char_code: expected %0d, actual %0d", want.char_code,
                      rsp_ch.char_code);
               error_count++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      req_idle_pct = 38;
      rsp_idle_pct = 53;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_value(directed_value[i], directed_text[i]);
      end
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (n == RANDOM_COUNT / 3) begin
            req_idle_pct = 53;
            rsp_idle_pct = 38;
         end
         if (n == 2 * RANDOM_COUNT / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
            hold_off_request = 1'b1;
         end
         send_value(random_value(), "");
      end
      req_ch.valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(5_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/dif_pkg.sv
sv/dif_if.sv
sv/dif_ctrl.sv
sv/dif_datapath.sv
sv/decimal_integer_formatter.sv
dv/tb_decimal_integer_formatter.sv
